[hdl/birz_pkg.sv]
// ----------------------------------------------------------------------------
// birz_pkg - shared types and constants for the boot image receiver
// Result item layout, item and verdict codes, register map and the
// byte-wide reflected CRC-32 step.
// ----------------------------------------------------------------------------
package birz_pkg;

    localparam logic [1:0]  KIND_LITERAL = 2'd0;
    localparam logic [1:0]  KIND_RUN     = 2'd1;
    localparam logic [1:0]  KIND_VERDICT = 2'd2;

    localparam logic [1:0]  VERD_OK      = 2'd0;
    localparam logic [1:0]  VERD_NOHDR   = 2'd1;
    localparam logic [1:0]  VERD_BADCRC  = 2'd2;

    localparam logic [7:0]  ACK_BYTE     = 8'h06;
    localparam logic [7:0]  NACK_BYTE    = 8'h15;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    localparam logic [31:0] HEADER_RESET = 32'h5847_4D49;
    localparam logic [15:0] LIMIT_RESET  = 16'd1000;

    // register index, taken from paddr[2]
    localparam logic        REG_HEADER   = 1'b0;
    localparam logic        REG_LIMIT    = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [7:0] run_length;
        logic [1:0] verdict;
        logic       is_last;
    } t_item;

    typedef struct packed {
        logic [31:0] header_word;
        logic [15:0] hunt_limit;
    } t_cfg;

    // items produced by one accepted byte, item0 first
    typedef struct packed {
        logic [1:0] count;
        t_item      item0;
        t_item      item1;
    } t_push;

    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/boot_image_receiver_zero_rle.sv]
// ----------------------------------------------------------------------------
// boot_image_receiver_zero_rle - framed image receiver with zero RLE decode
// Input channel: one received byte per transaction (i_in_valid/o_in_ready).
// The block hunts for the configured four-byte header, reads a 32-bit
// little-endian length, the payload and a little-endian CRC-32 over the
// payload. Payload bytes are decoded as they arrive (00 00 n is a run of n
// zeros) and go out as literal or run items; the frame ends with a verdict
// item carrying ACK or NACK.
// Output channel: one result item per transaction (o_out_valid/i_out_ready).
// A byte's result items are written into the registered queue when it is accepted.
// Throughput: one byte per cycle; the frame state is updated in the accept
// cycle and results go into a four-entry queue, so a byte is taken while
// earlier results wait. A byte yields at most two items; the input stalls
// only when the queue holds three or more items, i.e. while the receiver
// holds off long enough for it to fill.
// Reset: header word 0x58474D49, hunt limit 1000, queue emptied, hunt
// restarts. User writes registers over APB-style port while idle; unchecked.
// ----------------------------------------------------------------------------
module boot_image_receiver_zero_rle
    import birz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_item_kind,
    output logic [7:0]  o_byte_value,
    output logic [7:0]  o_run_length,
    output logic [1:0]  o_verdict,
    output logic        o_is_last
);

    t_cfg  w_cfg;
    t_push w_push;
    t_item w_item;
    logic  w_room;
    logic  w_accept;

    assign o_in_ready = w_room;
    assign w_accept   = i_in_valid && w_room;

    birz_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    birz_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (w_push)
    );

    birz_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (w_item)
    );

    assign o_item_kind  = w_item.kind;
    assign o_byte_value = w_item.byte_value;
    assign o_run_length = w_item.run_length;
    assign o_verdict    = w_item.verdict;
    assign o_is_last    = w_item.is_last;

endmodule

[hdl/birz_cfg.sv]
// ----------------------------------------------------------------------------
// birz_cfg - configuration registers
// APB-style write/read of the header word and the hunt limit.
// ----------------------------------------------------------------------------
module birz_cfg
    import birz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_word <= HEADER_RESET;
            r_cfg.hunt_limit  <= LIMIT_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_HEADER: r_cfg.header_word <= pwdata;
                REG_LIMIT:  r_cfg.hunt_limit  <= pwdata[15:0];
                default:    r_cfg.header_word <= r_cfg.header_word;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_HEADER: prdata = r_cfg.header_word;
            REG_LIMIT:  prdata = {16'd0, r_cfg.hunt_limit};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/birz_core.sv]
// ----------------------------------------------------------------------------
// birz_core - frame parser, CRC and zero run-length decoder
// Updates the frame state for each accepted byte and produces up to two
// result items for the output queue.
// ----------------------------------------------------------------------------
module birz_core
    import birz_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output t_push      o_push
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_CRC  = 2'd3;

    logic [1:0]  r_phase,   n_phase;
    logic [31:0] r_window,  n_window;
    logic [15:0] r_hunt,    n_hunt;
    logic [31:0] r_len,     n_len;
    logic [31:0] r_left,    n_left;
    logic [1:0]  r_fidx,    n_fidx;
    logic [31:0] r_crc,     n_crc;
    logic [31:0] r_crc_rx,  n_crc_rx;
    logic [1:0]  r_zpend,   n_zpend;
    t_push       w_push;
    logic [31:0] w_lane;
    logic        w_last;

    function automatic t_item mk_item(input logic [1:0] kind, input logic [7:0] b,
                                      input logic [7:0] run, input logic [1:0] verd,
                                      input logic last);
        t_item it;
        it.kind       = kind;
        it.byte_value = b;
        it.run_length = run;
        it.verdict    = verd;
        it.is_last    = last;
        return it;
    endfunction

    assign w_lane = {24'd0, i_rx_byte} << {r_fidx, 3'b000};

    always_comb begin
        n_phase  = r_phase;
        n_window = r_window;
        n_hunt   = r_hunt;
        n_len    = r_len;
        n_left   = r_left;
        n_fidx   = r_fidx;
        n_crc    = r_crc;
        n_crc_rx = r_crc_rx;
        n_zpend  = r_zpend;
        w_last   = 1'b0;
        w_push.count = 2'd0;
        w_push.item0 = mk_item(KIND_LITERAL, 8'd0, 8'd0, VERD_OK, 1'b0);
        w_push.item1 = mk_item(KIND_LITERAL, 8'd0, 8'd0, VERD_OK, 1'b0);

        unique case (r_phase)
            PH_HUNT: begin
                n_window = {i_rx_byte, r_window[31:8]};
                n_hunt   = r_hunt + 16'd1;
                if (n_window == i_cfg.header_word) begin
                    n_phase = PH_LEN;
                    n_fidx  = 2'd0;
                    n_len   = 32'd0;
                end else if (n_hunt >= i_cfg.hunt_limit) begin
                    w_push.count = 2'd1;
                    w_push.item0 = mk_item(KIND_VERDICT, NACK_BYTE, 8'd0, VERD_NOHDR, 1'b1);
                    n_phase  = PH_HUNT;
                    n_window = 32'd0;
                    n_hunt   = 16'd0;
                end
            end
            PH_LEN: begin
                n_len  = r_len | w_lane;
                n_fidx = r_fidx + 2'd1;
                if (r_fidx == 2'd3) begin
                    n_left   = n_len;
                    n_crc_rx = 32'd0;
                    n_phase  = (n_len == 32'd0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc  = crc_step(r_crc, i_rx_byte);
                n_left = r_left - 32'd1;
                w_last = (n_left == 32'd0);
                if (r_zpend == 2'd2) begin
                    // count byte of a 00 00 n group; a zero count gives nothing
                    if (i_rx_byte != 8'd0) begin
                        w_push.count = 2'd1;
                        w_push.item0 = mk_item(KIND_RUN, 8'd0, i_rx_byte, VERD_OK, 1'b0);
                    end
                    n_zpend = 2'd0;
                end else if (r_zpend == 2'd1) begin
                    if (i_rx_byte == 8'd0 && !w_last) begin
                        n_zpend = 2'd2;
                    end else begin
                        w_push.count = 2'd2;
                        w_push.item1 = mk_item(KIND_LITERAL, i_rx_byte, 8'd0, VERD_OK, 1'b0);
                        n_zpend = 2'd0;
                    end
                end else begin
                    if (i_rx_byte == 8'd0 && !w_last) begin
                        n_zpend = 2'd1;
                    end else begin
                        w_push.count = 2'd1;
                        w_push.item0 = mk_item(KIND_LITERAL, i_rx_byte, 8'd0, VERD_OK, 1'b0);
                    end
                end
                if (w_last) begin
                    n_phase = PH_CRC;
                    n_fidx  = 2'd0;
                end
            end
            PH_CRC: begin
                n_crc_rx = r_crc_rx | w_lane;
                n_fidx   = r_fidx + 2'd1;
                if (r_fidx == 2'd3) begin
                    w_push.count = 2'd1;
                    if (~r_crc == n_crc_rx) begin
                        w_push.item0 = mk_item(KIND_VERDICT, ACK_BYTE, 8'd0, VERD_OK, 1'b1);
                    end else begin
                        w_push.item0 = mk_item(KIND_VERDICT, NACK_BYTE, 8'd0, VERD_BADCRC,
                                               1'b1);
                    end
                    // restart the frame
                    n_phase  = PH_HUNT;
                    n_window = 32'd0;
                    n_hunt   = 16'd0;
                    n_len    = 32'd0;
                    n_left   = 32'd0;
                    n_fidx   = 2'd0;
                    n_crc    = CRC_INIT;
                    n_crc_rx = 32'd0;
                    n_zpend  = 2'd0;
                end
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_window <= 32'd0;
            r_hunt   <= 16'd0;
            r_len    <= 32'd0;
            r_left   <= 32'd0;
            r_fidx   <= 2'd0;
            r_crc    <= CRC_INIT;
            r_crc_rx <= 32'd0;
            r_zpend  <= 2'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_hunt   <= n_hunt;
            r_len    <= n_len;
            r_left   <= n_left;
            r_fidx   <= n_fidx;
            r_crc    <= n_crc;
            r_crc_rx <= n_crc_rx;
            r_zpend  <= n_zpend;
        end
    end

    always_comb begin
        o_push = w_push;
        if (!i_accept) begin
            o_push.count = 2'd0;
        end
    end

endmodule

[hdl/birz_outq.sv]
// ----------------------------------------------------------------------------
// birz_outq - result queue
// Four-entry queue that takes up to two items per cycle and hands one
// item per transaction to the output channel.
// ----------------------------------------------------------------------------
module birz_outq
    import birz_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item      r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;
    logic       w_pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_room  = (r_cnt <= 3'd2);
    assign o_item  = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr + i_push.count;
        n_rd  = r_rd + {1'b0, w_pop};
        n_cnt = r_cnt + {1'b0, i_push.count} - {2'd0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.item0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[tb/sv/tb_boot_image_receiver_zero_rle.sv]
// ----------------------------------------------------------------------------
// tb_boot_image_receiver_zero_rle - self-checking bench for the image receiver
// Feeds framed byte streams (header, little-endian length, zero-RLE payload,
// CRC-32) through the input channel. A predictor tracks the frame state and
// queues the literal, run and verdict items each accepted byte should yield.
// The monitor checks every output transaction against the oldest prediction.
// Phases vary the header word, the hunt limit and the idling on both sides.
// ----------------------------------------------------------------------------
module tb_boot_image_receiver_zero_rle
    import birz_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 55;
    localparam int SHOWN_ERRORS = 20;

    typedef enum logic [1:0] {RX_HUNT, RX_LEN, RX_DATA, RX_CRC} t_rx_phase;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte    = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [1:0]  o_item_kind;
    logic [7:0]  o_byte_value;
    logic [7:0]  o_run_length;
    logic [1:0]  o_verdict;
    logic        o_is_last;

    // stimulus and scoreboard storage
    logic [7:0]  rx_pending[$];
    logic [7:0]  payload_buf[$];
    t_item       predicted_items[$];
    int          sent_in_phase = 0;
    int          err_cnt       = 0;
    int          cycle_cnt     = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          in_taken      = 1'b0;
    bit          hold_arm      = 1'b0;
    bit          hold_seen     = 1'b0;
    int          hold_left     = 0;

    // predictor copy of configuration and frame state
    logic [31:0] cfg_header = HEADER_RESET;
    logic [15:0] cfg_limit  = LIMIT_RESET;
    t_rx_phase   rx_phase;
    logic [31:0] hdr_window;
    logic [15:0] hunt_cnt;
    logic [31:0] frame_len;
    logic [31:0] bytes_left;
    logic [1:0]  field_idx;
    logic [31:0] crc_run;
    logic [31:0] crc_seen;
    int          zeros_held;

    boot_image_receiver_zero_rle i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_item_kind  (o_item_kind),
        .o_byte_value (o_byte_value),
        .o_run_length (o_run_length),
        .o_verdict    (o_verdict),
        .o_is_last    (o_is_last)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[31:1]};
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic frame_rearm();
        rx_phase   = RX_HUNT;
        hdr_window = '0;
        hunt_cnt   = '0;
        frame_len  = '0;
        bytes_left = '0;
        field_idx  = '0;
        crc_run    = CRC_INIT;
        crc_seen   = '0;
        zeros_held = 0;
    endtask

    task automatic push_item(input logic [1:0] kind, input logic [7:0] val,
                             input logic [7:0] run, input logic [1:0] verd,
                             input logic last);
        t_item it;
        it.kind       = kind;
        it.byte_value = val;
        it.run_length = run;
        it.verdict    = verd;
        it.is_last    = last;
        predicted_items.push_back(it);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic is_end;
        case (rx_phase)
            RX_HUNT: begin
                hdr_window = {b, hdr_window[31:8]};
                hunt_cnt   = hunt_cnt + 16'd1;
                if (hdr_window == cfg_header) begin
                    rx_phase  = RX_LEN;
                    field_idx = '0;
                    frame_len = '0;
                end else if (hunt_cnt >= cfg_limit) begin
                    push_item(KIND_VERDICT, NACK_BYTE, 8'h00, VERD_NOHDR, 1'b1);
                    frame_rearm();
                end
            end
            RX_LEN: begin
                frame_len[8*field_idx +: 8] = b;
                field_idx = field_idx + 2'd1;
                if (field_idx == 2'd0) begin
                    bytes_left = frame_len;
                    crc_seen   = '0;
                    rx_phase   = (frame_len == 0) ? RX_CRC : RX_DATA;
                end
            end
            RX_DATA: begin
                crc_run    = crc32_next(crc_run, b);
                bytes_left = bytes_left - 32'd1;
                is_end     = (bytes_left == 0);
                if (zeros_held == 2) begin
                    // count byte of a 00 00 n run; a zero count yields nothing
                    if (b != 8'h00) push_item(KIND_RUN, 8'h00, b, VERD_OK, 1'b0);
                    zeros_held = 0;
                end else if (zeros_held == 1) begin
                    if (b == 8'h00) begin
                        if (is_end) begin
                            push_item(KIND_LITERAL, 8'h00, 8'h00, VERD_OK, 1'b0);
                            push_item(KIND_LITERAL, 8'h00, 8'h00, VERD_OK, 1'b0);
                            zeros_held = 0;
                        end else begin
                            zeros_held = 2;
                        end
                    end else begin
                        push_item(KIND_LITERAL, 8'h00, 8'h00, VERD_OK, 1'b0);
                        push_item(KIND_LITERAL, b, 8'h00, VERD_OK, 1'b0);
                        zeros_held = 0;
                    end
                end else if (b == 8'h00 && !is_end) begin
                    zeros_held = 1;
                end else begin
                    push_item(KIND_LITERAL, b, 8'h00, VERD_OK, 1'b0);
                end
                if (is_end) begin
                    rx_phase  = RX_CRC;
                    field_idx = '0;
                end
            end
            default: begin
                crc_seen[8*field_idx +: 8] = b;
                field_idx = field_idx + 2'd1;
                if (field_idx == 2'd0) begin
                    if (~crc_run == crc_seen)
                        push_item(KIND_VERDICT, ACK_BYTE, 8'h00, VERD_OK, 1'b1);
                    else
                        push_item(KIND_VERDICT, NACK_BYTE, 8'h00, VERD_BADCRC, 1'b1);
                    frame_rearm();
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            err_cnt++;
            if (err_cnt <= SHOWN_ERRORS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_item();
        t_item want;
        if (predicted_items.size() == 0) begin
            err_cnt++;
            if (err_cnt <= SHOWN_ERRORS)
                $display("%0t: unexpected item, expected none, actual kind %0h value %0h",
                         $time, o_item_kind, o_byte_value);
        end else begin
            want = predicted_items.pop_front();
            compare_field("item_kind", want.kind, o_item_kind);
            compare_field("byte_value", want.byte_value, o_byte_value);
            compare_field("run_length", want.run_length, o_run_length);
            compare_field("verdict", want.verdict, o_verdict);
            compare_field("is_last", want.is_last, o_is_last);
        end
    endtask

    // monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) decode_byte(i_rx_byte);
            if (o_out_valid && i_out_ready) check_item();
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // driver: hold valid and payload until the transaction is taken
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_rx_byte  <= rx_pending.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_arm != hold_seen) begin
            hold_seen   <= hold_arm;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic reg_write(input logic reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_HEADER) cfg_header = value;
        else cfg_limit = value[15:0];
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        sent_in_phase++;
    endtask

    // a header whose low bytes are zero matches before all four bytes are in
    task automatic queue_header(input int n_noise);
        int k;
        k = 4;
        if (cfg_header[23:0] == 0) k = 1;
        else if (cfg_header[15:0] == 0) k = 2;
        else if (cfg_header[7:0] == 0) k = 3;
        if (k == 4) repeat (n_noise) queue_byte(8'($urandom_range(255)));
        for (int j = 4 - k; j < 4; j++) queue_byte(cfg_header[8*j +: 8]);
    endtask

    task automatic queue_body(input bit corrupt);
        logic [31:0] crc;
        logic [31:0] len;
        crc = CRC_INIT;
        len = payload_buf.size();
        for (int j = 0; j < 4; j++) queue_byte(len[8*j +: 8]);
        foreach (payload_buf[j]) begin
            crc = crc32_next(crc, payload_buf[j]);
            queue_byte(payload_buf[j]);
        end
        crc = ~crc;
        if (corrupt) crc = crc ^ (32'h1 << $urandom_range(31));
        for (int j = 0; j < 4; j++) queue_byte(crc[8*j +: 8]);
    endtask

    task automatic queue_frame();
        int          r;
        int          len;
        int          n_noise;
        logic [7:0]  b;
        r = $urandom_range(99);
        if (r < 8 && cfg_limit <= 64) begin
            // junk that runs the hunt out; steer clear of a one-byte header match
            repeat (cfg_limit) begin
                b = 8'($urandom_range(255));
                if (b == cfg_header[31:24]) b = ~b;
                queue_byte(b);
            end
        end else begin
            n_noise = (cfg_header[7:0] != 0 && cfg_limit >= 7) ? $urandom_range(3) : 0;
            queue_header(n_noise);
            len = ($urandom_range(99) < 85) ? $urandom_range(16) : $urandom_range(40, 17);
            payload_buf.delete();
            while (payload_buf.size() < len) begin
                r = $urandom_range(99);
                if (r < 15 && len - payload_buf.size() >= 3) begin
                    payload_buf.push_back(8'h00);
                    payload_buf.push_back(8'h00);
                    payload_buf.push_back(8'($urandom_range(255)));
                end else if (r < 55) begin
                    payload_buf.push_back(8'h00);
                end else if (r < 62) begin
                    payload_buf.push_back(8'hFF);
                end else begin
                    payload_buf.push_back(8'($urandom_range(255)));
                end
            end
            queue_body($urandom_range(99) < 15);
        end
    endtask

    // hold the sender until every predicted item has come out
    task automatic wait_drain();
        while (rx_pending.size() != 0 || i_in_valid || predicted_items.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        @(posedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent_in_phase  = 0;
        while (sent_in_phase < PHASE_BYTES) queue_frame();
        wait_drain();
    endtask

    initial begin
        frame_rearm();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // runs, zero followed by a literal, zero-count run, trailing zero pair
        payload_buf = '{8'h00, 8'h00, 8'h05, 8'h00, 8'h07, 8'hFF,
                        8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_header(0);
        queue_body(1'b0);
        wait_drain();

        // header completed on the last allowed byte, then an empty payload
        reg_write(REG_LIMIT, 32'd4);
        queue_header(0);
        payload_buf.delete();
        queue_body(1'b0);
        wait_drain();

        // hunt limit of one: the first byte gives up
        reg_write(REG_LIMIT, 32'd1);
        queue_byte(8'h00);
        wait_drain();

        // fill the result queue behind a long receiver hold-off
        reg_write(REG_LIMIT, {16'd0, LIMIT_RESET});
        @(posedge i_clk);
        hold_arm = ~hold_arm;
        run_phase(0, 0);

        reg_write(REG_HEADER, $urandom);
        reg_write(REG_LIMIT, 32'd65535);
        run_phase(58, 0);

        reg_write(REG_HEADER, 32'hFFFF_FFFF);
        reg_write(REG_LIMIT, 32'd20);
        run_phase(0, 58);

        reg_write(REG_HEADER, 32'h0000_0000);
        reg_write(REG_LIMIT, 32'd1);
        run_phase(25, 25);

        reg_write(REG_HEADER, 32'hA5C3_0000);
        reg_write(REG_LIMIT, 32'd300);
        run_phase(0, 0);

        reg_write(REG_HEADER, HEADER_RESET);
        reg_write(REG_LIMIT, 32'd40);
        run_phase(25, 25);

        if (predicted_items.size() != 0) begin
            err_cnt++;
            $display("%0t: items left over, expected 0, actual %0d",
                     $time, predicted_items.size());
        end
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
hdl/birz_pkg.sv
hdl/birz_cfg.sv
hdl/birz_core.sv
hdl/birz_outq.sv
hdl/boot_image_receiver_zero_rle.sv
tb/sv/tb_boot_image_receiver_zero_rle.sv
